// ===== rtl/dtcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcp_pkg
// shared types, constants and lookup functions of the depth false-color map
// ----------------------------------------------------------------------------
package dtcp_pkg;

   // widest depth sample handled internally
   localparam int DEPTH_MAX_BITS = 16;

   // width of the shifted piece numerator
   localparam int X_BITS = 23;

   // reciprocal width and product width of the level divider
   localparam int RECIP_BITS = 32;
   localparam int PROD_BITS  = X_BITS + RECIP_BITS;

   // level k in q1.16
   localparam int K_BITS = 17;
   localparam logic [K_BITS-1:0] K_ONE = 17'h10000;

   // reciprocals ceil(2^32 / n), exact for numerators below 2^23
   localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;
   localparam logic [RECIP_BITS-1:0] RECIP_3   = 32'((TWO_POW_32 + 64'd2) / 64'd3);
   localparam logic [RECIP_BITS-1:0] RECIP_5   = 32'((TWO_POW_32 + 64'd4) / 64'd5);
   localparam logic [RECIP_BITS-1:0] RECIP_25  = 32'((TWO_POW_32 + 64'd24) / 64'd25);
   localparam logic [RECIP_BITS-1:0] RECIP_39  = 32'((TWO_POW_32 + 64'd38) / 64'd39);
   localparam logic [RECIP_BITS-1:0] RECIP_251 = 32'((TWO_POW_32 + 64'd250) / 64'd251);

   // focus region codes
   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_NEAR,
      MODE_MIDDLE,
      MODE_FAR
   } depth_mode_type;

   // linear piece of the depth curve
   typedef enum logic [1:0] {
      PIECE_LOW,
      PIECE_MID,
      PIECE_HIGH
   } piece_type;

   // how the piece term combines with its base level
   typedef enum logic [1:0] {
      OP_SUB,
      OP_ADD_SAT,
      OP_ZERO
   } level_op_type;

   // break points of one focus region
   typedef struct packed {
      logic [13:0] t1;
      logic [13:0] t2;
   } mode_thr_type;

   // k = base op floor((d - offset) * 2^shift / divisor)
   typedef struct packed {
      logic [13:0]           offset;
      logic [3:0]            shift;
      logic                  use_recip;
      logic [RECIP_BITS-1:0] recip;
      logic [K_BITS-1:0]     base;
      level_op_type          op;
   } piece_cfg_type;

   function automatic mode_thr_type mode_thresholds(depth_mode_type mode);
      mode_thr_type thr;
      case (mode)
         MODE_NORMAL: thr = '{t1: 14'd2048, t2: 14'd4096};
         MODE_NEAR:   thr = '{t1: 14'd4096, t2: 14'd8192};
         MODE_MIDDLE: thr = '{t1: 14'd1600, t2: 14'd4096};
         MODE_FAR:    thr = '{t1: 14'd40,   t2: 14'd2048};
         default:     thr = '{t1: 14'd2048, t2: 14'd4096};
      endcase
      return thr;
   endfunction

   function automatic piece_cfg_type make_piece(
      logic [13:0]           offset,
      logic [3:0]            shift,
      logic                  use_recip,
      logic [RECIP_BITS-1:0] recip,
      logic [K_BITS-1:0]     base,
      level_op_type          op
   );
      piece_cfg_type cfg;
      cfg.offset    = offset;
      cfg.shift     = shift;
      cfg.use_recip = use_recip;
      cfg.recip     = recip;
      cfg.base      = base;
      cfg.op        = op;
      return cfg;
   endfunction

   // slopes of the three pieces per focus region
   function automatic piece_cfg_type piece_config(depth_mode_type mode, piece_type piece);
      piece_cfg_type cfg;
      cfg = make_piece(14'd0, 4'd0, 1'b0, '0, '0, OP_ZERO);
      case (mode)
         MODE_NORMAL: begin
            case (piece)
               PIECE_LOW: cfg = make_piece(14'd0, 4'd3, 1'b0, '0, K_ONE, OP_SUB);
               PIECE_MID: cfg = make_piece(14'd2048, 4'd4, 1'b0, '0, 17'd49152, OP_SUB);
               default:   cfg = make_piece(14'd4096, 4'd3, 1'b0, '0, 17'd16384, OP_ADD_SAT);
            endcase
         end
         MODE_NEAR: begin
            case (piece)
               PIECE_LOW: cfg = make_piece(14'd0, 4'd2, 1'b0, '0, K_ONE, OP_SUB);
               PIECE_MID: cfg = make_piece(14'd4096, 4'd3, 1'b0, '0, 17'd49152, OP_SUB);
               default:   cfg = make_piece(14'd8192, 4'd3, 1'b1, RECIP_3, 17'd16384,
                                           OP_ADD_SAT);
            endcase
         end
         MODE_MIDDLE: begin
            case (piece)
               PIECE_LOW: cfg = make_piece(14'd0, 4'd8, 1'b1, RECIP_25, K_ONE, OP_SUB);
               PIECE_MID: cfg = make_piece(14'd1600, 4'd9, 1'b1, RECIP_39, 17'd49152, OP_SUB);
               default:   cfg = make_piece(14'd4096, 4'd3, 1'b0, '0, 17'd16384, OP_ADD_SAT);
            endcase
         end
         MODE_FAR: begin
            case (piece)
               PIECE_LOW: cfg = make_piece(14'd0, 4'd11, 1'b1, RECIP_5, K_ONE, OP_SUB);
               PIECE_MID: cfg = make_piece(14'd40, 4'd12, 1'b1, RECIP_251, 17'd49152, OP_SUB);
               default:   cfg = make_piece(14'd2048, 4'd0, 1'b0, '0, '0, OP_ZERO);
            endcase
         end
         default: cfg = make_piece(14'd0, 4'd0, 1'b0, '0, '0, OP_ZERO);
      endcase
      return cfg;
   endfunction

   // color ramp: band operand widths and multiples of one unit of 20*k
   localparam int OPND_BITS = 20;
   localparam int CPROD_BITS = 28;
   localparam logic [OPND_BITS-1:0] U2  = 20'h20000;
   localparam logic [OPND_BITS-1:0] U4  = 20'h40000;
   localparam logic [OPND_BITS-1:0] U6  = 20'h60000;
   localparam logic [OPND_BITS-1:0] U12 = 20'hC0000;

   // floor(v / 3) for v below 2048 as (v * 1366) >> 12
   localparam logic [10:0] DIV3_RECIP = 11'd1366;
   localparam int DIV3_SHIFT = 12;

   typedef enum logic [3:0] {
      BAND_0,
      BAND_1,
      BAND_2,
      BAND_3,
      BAND_4,
      BAND_5,
      BAND_6,
      BAND_7,
      BAND_8
   } band_type;

   // channel = offset + floor(scale * operand / 2^shift), optionally divided by 3
   typedef struct packed {
      logic [7:0]           offset;
      logic [7:0]           scale;
      logic [OPND_BITS-1:0] operand;
      logic [4:0]           shift;
      logic                 div3;
   } chan_op_type;

endpackage

// ===== rtl/dtcp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcp_if
// valid/ready channels for depth samples and false-color pixels
// ----------------------------------------------------------------------------

// depth sample channel
interface dtcp_req_if #(
   parameter int DEPTH_BITS = 14
);
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] depth;

   modport source (output valid, output depth, input ready);
   modport sink   (input valid, input depth, output ready);
endinterface

// false-color pixel channel
interface dtcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/depth_to_color_palette_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_color_palette_map
// false-color rendering of raw depth samples
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one depth sample per transaction, rsp_chan returns its
//   red, green and blue bytes, one response per request, in order.
//   csr_wr_en / csr_wr_data write the 2-bit focus mode (normal, near, middle,
//   far); write it only while no transaction is in flight.
// pipeline and throughput
//   six register stages: a sample accepted on req_chan passes the three
//   level stages and then the three color stages before it is presented
//   on rsp_chan.
//   one transaction per clock while rsp_chan.ready stays high; each stage
//   holds one transaction and no stage iterates, so the level divider and
//   the channel multipliers each take a full stage.
// reset
//   synchronous, active high: the pipeline empties and the mode returns to
//   normal.
// stalls
//   a stalled response holds its bytes; earlier stages keep filling bubbles
//   and req_chan.ready drops only when all six stages are occupied.
// ----------------------------------------------------------------------------
module depth_to_color_palette_map #(
   parameter int DEPTH_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data,
   dtcp_req_if.sink   req_chan,
   dtcp_rsp_if.source rsp_chan
);
   import dtcp_pkg::*;

   // focus mode register
   depth_mode_type mode_ff, mode_in;

   // level handoff between the two halves
   logic              lvl_valid;
   logic              lvl_ready;
   logic [K_BITS-1:0] lvl_k;

   assign mode_in = csr_wr_en ? depth_mode_type'(csr_wr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // depth to level
   dtcp_level #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_level (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_depth  (req_chan.depth),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_level (lvl_k)
   );

   // level to color
   dtcp_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_level  (lvl_k),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_red   (rsp_chan.red),
      .out_green (rsp_chan.green),
      .out_blue  (rsp_chan.blue)
   );

endmodule

// ===== rtl/dtcp_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcp_level
// three-stage pipeline mapping a depth sample to its q1.16 level k
// ----------------------------------------------------------------------------
module dtcp_level #(
   parameter int DEPTH_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dtcp_pkg::depth_mode_type     mode,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [DEPTH_BITS-1:0]        in_depth,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [dtcp_pkg::K_BITS-1:0]  out_level
);
   import dtcp_pkg::*;

   // stage enables, a stage moves when it is empty or its successor moves
   logic en1_w, en2_w, en3_w;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   // stage 1 registers
   logic [X_BITS-1:0]     x_ff, x_in;
   logic [RECIP_BITS-1:0] recip_ff, recip_in;
   logic                  use_recip_ff, use_recip_in;
   logic [K_BITS-1:0]     base1_ff, base1_in;
   level_op_type          op1_ff, op1_in;

   // stage 2 registers
   logic [X_BITS-1:0]     q_ff, q_in;
   logic [K_BITS-1:0]     base2_ff;
   level_op_type          op2_ff;

   // stage 3 registers
   logic [K_BITS-1:0]     k_ff, k_in;

   // stage 1 work signals
   logic [DEPTH_MAX_BITS-1:0] d_w;
   logic [DEPTH_MAX_BITS-1:0] diff_w;
   mode_thr_type              thr_w;
   piece_type                 piece_w;
   piece_cfg_type             cfg_w;

   // stage 2 and 3 work signals
   logic [PROD_BITS-1:0] prod_w;
   logic [23:0]          sum_w;
   logic [23:0]          dif_w;

   // handshake chain
   assign en3_w     = !v3_ff || out_ready;
   assign en2_w     = !v2_ff || en3_w;
   assign en1_w     = !v1_ff || en2_w;
   assign in_ready  = en1_w;
   assign out_valid = v3_ff;
   assign out_level = k_ff;

   assign v1_in = en1_w ? in_valid : v1_ff;
   assign v2_in = en2_w ? v1_ff : v2_ff;
   assign v3_in = en3_w ? v2_ff : v3_ff;

   // stage 1: pick the piece and form the shifted numerator
   always_comb begin
      d_w   = DEPTH_MAX_BITS'(in_depth);
      thr_w = mode_thresholds(mode);
      if (d_w < {2'b00, thr_w.t1}) begin
         piece_w = PIECE_LOW;
      end else if (d_w < {2'b00, thr_w.t2}) begin
         piece_w = PIECE_MID;
      end else begin
         piece_w = PIECE_HIGH;
      end
      cfg_w        = piece_config(mode, piece_w);
      diff_w       = d_w - {2'b00, cfg_w.offset};
      x_in         = X_BITS'({7'b0, diff_w} << cfg_w.shift);
      recip_in     = cfg_w.recip;
      use_recip_in = cfg_w.use_recip;
      base1_in     = cfg_w.base;
      op1_in       = cfg_w.op;
   end

   // stage 2: divide by the piece's constant through its reciprocal, or pass x through
   assign prod_w = PROD_BITS'(x_ff) * PROD_BITS'(recip_ff);
   assign q_in   = use_recip_ff ? prod_w[PROD_BITS-1:RECIP_BITS] : x_ff;

   // stage 3: combine with the base level and clamp
   assign sum_w = 24'(base2_ff) + 24'(q_ff);
   assign dif_w = 24'(base2_ff) - 24'(q_ff);

   always_comb begin
      case (op2_ff)
         OP_SUB:     k_in = dif_w[K_BITS-1:0];
         OP_ADD_SAT: k_in = (sum_w > 24'(K_ONE)) ? K_ONE : sum_w[K_BITS-1:0];
         OP_ZERO:    k_in = '0;
         default:    k_in = '0;
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1_w) begin
         x_ff         <= x_in;
         recip_ff     <= recip_in;
         use_recip_ff <= use_recip_in;
         base1_ff     <= base1_in;
         op1_ff       <= op1_in;
      end
      if (en2_w) begin
         q_ff     <= q_in;
         base2_ff <= base1_ff;
         op2_ff   <= op1_ff;
      end
      if (en3_w) begin
         k_ff <= k_in;
      end
   end

   // level never leaves 0..1
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (k_ff <= K_ONE))
      else $error("level above one");

   // falling pieces never run below zero
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && (op2_ff == OP_SUB)) |-> (24'(q_ff) <= 24'(base2_ff)))
      else $error("level piece underflow");

   // input is held off only when every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("stall with a free stage");

endmodule

// ===== rtl/dtcp_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtcp_color
// three-stage pipeline turning level k into red, green and blue bytes
// ----------------------------------------------------------------------------
module dtcp_color (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [dtcp_pkg::K_BITS-1:0] in_level,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [7:0]                  out_red,
   output logic [7:0]                  out_green,
   output logic [7:0]                  out_blue
);
   import dtcp_pkg::*;

   function automatic chan_op_type make_op(
      logic [7:0]           offset,
      logic [7:0]           scale,
      logic [OPND_BITS-1:0] operand,
      logic [4:0]           shift,
      logic                 div3
   );
      chan_op_type op;
      op.offset  = offset;
      op.scale   = scale;
      op.operand = operand;
      op.shift   = shift;
      op.div3    = div3;
      return op;
   endfunction

   function automatic chan_op_type const_op(logic [7:0] value);
      return make_op(value, 8'd0, '0, 5'd0, 1'b0);
   endfunction

   // stage enables and valid bits
   logic en1_w, en2_w, en3_w;
   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;

   // stage 1: per-channel recipe
   chan_op_type op_r_ff, op_g_ff, op_b_ff;
   chan_op_type op_r_in, op_g_in, op_b_in;

   // stage 2: per-channel products
   logic [CPROD_BITS-1:0] prod_ff [3];
   logic [CPROD_BITS-1:0] prod_in [3];
   logic [7:0]            off_ff  [3];
   logic [4:0]            sh_ff   [3];
   logic                  div3_ff [3];

   // stage 3: output bytes
   logic [7:0] chan_ff [3];
   logic [7:0] chan_in [3];

   // stage 1 work signals
   logic [20:0]          k20_w;
   logic [4:0]           hi_w;
   logic [4:0]           edge_w;
   band_type             band_w;
   logic [OPND_BITS-1:0] o_w;
   logic [OPND_BITS-1:0] os_w;

   // stage 3 work signals
   logic [CPROD_BITS-1:0] shifted_w [3];
   logic [20:0]           third_w   [3];
   logic [9:0]            val_w     [3];
   logic [8:0]            sum9_w    [3];

   // handshake chain
   assign en3_w     = !v3_ff || out_ready;
   assign en2_w     = !v2_ff || en3_w;
   assign en1_w     = !v1_ff || en2_w;
   assign in_ready  = en1_w;
   assign out_valid = v3_ff;
   assign out_red   = chan_ff[0];
   assign out_green = chan_ff[1];
   assign out_blue  = chan_ff[2];

   assign v1_in = en1_w ? in_valid : v1_ff;
   assign v2_in = en2_w ? v1_ff : v2_ff;
   assign v3_in = en3_w ? v2_ff : v3_ff;

   // stage 1: 20*k, its band and offset into the band
   always_comb begin
      k20_w = (21'(in_level) << 4) + (21'(in_level) << 2);
      hi_w  = k20_w[20:16];
      if (hi_w < 5'd2) begin
         band_w = BAND_0; edge_w = 5'd0;
      end else if (hi_w < 5'd4) begin
         band_w = BAND_1; edge_w = 5'd2;
      end else if (hi_w < 5'd7) begin
         band_w = BAND_2; edge_w = 5'd4;
      end else if (hi_w < 5'd10) begin
         band_w = BAND_3; edge_w = 5'd7;
      end else if (hi_w < 5'd12) begin
         band_w = BAND_4; edge_w = 5'd10;
      end else if (hi_w < 5'd14) begin
         band_w = BAND_5; edge_w = 5'd12;
      end else if (hi_w < 5'd16) begin
         band_w = BAND_6; edge_w = 5'd14;
      end else if (hi_w < 5'd18) begin
         band_w = BAND_7; edge_w = 5'd16;
      end else begin
         band_w = BAND_8; edge_w = 5'd18;
      end
      o_w  = OPND_BITS'(k20_w - {edge_w, 16'h0000});
      os_w = (o_w > U2) ? U2 : o_w;
   end

   // stage 1: channel recipes of each band
   always_comb begin
      case (band_w)
         BAND_0: begin
            op_r_in = make_op(8'd128, 8'd127, o_w, 5'd17, 1'b0);
            op_g_in = op_r_in;
            op_b_in = op_r_in;
         end
         BAND_1: begin
            op_r_in = const_op(8'd255);
            op_g_in = make_op(8'd0, 8'd255, U2 - o_w, 5'd17, 1'b0);
            op_b_in = op_g_in;
         end
         BAND_2: begin
            op_r_in = const_op(8'd255);
            op_g_in = make_op(8'd0, 8'd255, o_w, 5'd16, 1'b1);
            op_b_in = const_op(8'd0);
         end
         BAND_3: begin
            op_r_in = make_op(8'd0, 8'd255, U6 - o_w, 5'd17, 1'b1);
            op_g_in = make_op(8'd0, 8'd255, U12 - o_w, 5'd18, 1'b1);
            op_b_in = const_op(8'd0);
         end
         BAND_4: begin
            op_r_in = make_op(8'd0, 8'd1, U2 - o_w, 5'd10, 1'b0);
            op_g_in = const_op(8'd196);
            op_b_in = make_op(8'd0, 8'd1, o_w, 5'd10, 1'b0);
         end
         BAND_5: begin
            op_r_in = const_op(8'd0);
            op_g_in = const_op(8'd196);
            op_b_in = make_op(8'd128, 8'd127, o_w, 5'd17, 1'b0);
         end
         BAND_6: begin
            op_r_in = const_op(8'd0);
            op_g_in = make_op(8'd0, 8'd196, U2 - o_w, 5'd17, 1'b0);
            op_b_in = const_op(8'd255);
         end
         BAND_7: begin
            op_r_in = make_op(8'd0, 8'd1, o_w, 5'd10, 1'b0);
            op_g_in = const_op(8'd0);
            op_b_in = make_op(8'd0, 8'd255, U4 - o_w, 5'd18, 1'b0);
         end
         BAND_8: begin
            op_r_in = make_op(8'd0, 8'd1, U2 - os_w, 5'd10, 1'b0);
            op_g_in = const_op(8'd0);
            op_b_in = op_r_in;
         end
         default: begin
            op_r_in = const_op(8'd0);
            op_g_in = const_op(8'd0);
            op_b_in = const_op(8'd0);
         end
      endcase
   end

   // stage 2: scale times operand per channel
   assign prod_in[0] = CPROD_BITS'(op_r_ff.scale) * CPROD_BITS'(op_r_ff.operand);
   assign prod_in[1] = CPROD_BITS'(op_g_ff.scale) * CPROD_BITS'(op_g_ff.operand);
   assign prod_in[2] = CPROD_BITS'(op_b_ff.scale) * CPROD_BITS'(op_b_ff.operand);

   // stage 3: truncate, optional third, add offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted_w[i] = prod_ff[i] >> sh_ff[i];
         third_w[i]   = (21'(shifted_w[i][9:0]) * 21'(DIV3_RECIP)) >> DIV3_SHIFT;
         val_w[i]     = div3_ff[i] ? third_w[i][9:0] : shifted_w[i][9:0];
         sum9_w[i]    = 9'(off_ff[i]) + 9'(val_w[i][7:0]);
         chan_in[i]   = sum9_w[i][7:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1_w) begin
         op_r_ff <= op_r_in;
         op_g_ff <= op_g_in;
         op_b_ff <= op_b_in;
      end
      if (en2_w) begin
         prod_ff[0] <= prod_in[0];
         prod_ff[1] <= prod_in[1];
         prod_ff[2] <= prod_in[2];
         off_ff[0]  <= op_r_ff.offset;
         off_ff[1]  <= op_g_ff.offset;
         off_ff[2]  <= op_b_ff.offset;
         sh_ff[0]   <= op_r_ff.shift;
         sh_ff[1]   <= op_g_ff.shift;
         sh_ff[2]   <= op_b_ff.shift;
         div3_ff[0] <= op_r_ff.div3;
         div3_ff[1] <= op_g_ff.div3;
         div3_ff[2] <= op_b_ff.div3;
      end
      if (en3_w) begin
         chan_ff[0] <= chan_in[0];
         chan_ff[1] <= chan_in[1];
         chan_ff[2] <= chan_in[2];
      end
   end

   // truncated products fit the third-divider input
   a_shift_fits: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ((shifted_w[0][CPROD_BITS-1:10] == '0) &&
                 (shifted_w[1][CPROD_BITS-1:10] == '0) &&
                 (shifted_w[2][CPROD_BITS-1:10] == '0)))
      else $error("channel product out of range");

   // offset plus ramp term stays a byte
   a_byte_fits: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> ((sum9_w[0] <= 9'd255) && (sum9_w[1] <= 9'd255) &&
                 (sum9_w[2] <= 9'd255) && (val_w[0][9:8] == 2'b00) &&
                 (val_w[1][9:8] == 2'b00) && (val_w[2][9:8] == 2'b00)))
      else $error("channel byte overflow");

   // input is held off only when every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("stall with a free stage");

endmodule
